[src/lsim_pkg.sv]
`timescale 1ns / 1ps
// types and constants shared by the lattice site index mapper
// no dependencies

package lsim_pkg;

    localparam int EXT_W   = 9;   // extent register width
    localparam int CRD_W   = 10;  // signed input coordinate width
    localparam int IDX_W   = 32;  // site index width
    localparam int COUT_W  = 8;   // output coordinate width
    localparam int DIV_W   = IDX_W + 1;  // dividend, room for the even/odd doubling
    localparam int DIV_BPS = 6;   // quotient bits resolved per divider stage
    localparam int DIV_ST  = (DIV_W + DIV_BPS - 1) / DIV_BPS;

    localparam logic [1:0] CFG_EXT_X = 2'd0;
    localparam logic [1:0] CFG_EXT_Y = 2'd1;
    localparam logic [1:0] CFG_EXT_Z = 2'd2;
    localparam logic [1:0] CFG_EXT_T = 2'd3;

    typedef enum logic [1:0] {
        OP_TO_LEX   = 2'd0,
        OP_TO_EO    = 2'd1,
        OP_FROM_LEX = 2'd2,
        OP_FROM_EO  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [CRD_W-1:0]   coord_x;
        logic [CRD_W-1:0]   coord_y;
        logic [CRD_W-1:0]   coord_z;
        logic [CRD_W-1:0]   coord_t;
        logic [IDX_W-1:0]   site_index;
        logic               parity_in;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]   index_out;
        logic [COUT_W-1:0]  x_out;
        logic [COUT_W-1:0]  y_out;
        logic [COUT_W-1:0]  z_out;
        logic [COUT_W-1:0]  t_out;
        logic               parity_out;
        logic               range_error;
    } t_out_word;

endpackage

[src/lattice_site_index_mapper.sv]
`timescale 1ns / 1ps
// Lattice site index mapper: converts between 4-D periodic coordinates and
// lexicographic or even/odd site indices (x fastest, t slowest).
// Input channel i_valid / o_stall carries one t_in_word; output channel
// o_valid / i_stall carries one t_out_word per input word.
// Extents are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle;
// 0 acts as 1 and values above MAX_EXTENT act as MAX_EXTENT.
// Each word passes through three chained pipelined dividers (x, y, z), each
// resolving six quotient bits per stage, on its way from acceptance to o_valid.
// Throughput is one word per cycle unless i_stall freezes the pipeline.
// The coordinate-to-index path (wrap, then three multiply-add stages) runs in
// parallel and is delayed to the same depth.
// Reset clears all valid bits and sets every extent to 4.
// When the output word is held by i_stall the whole pipeline freezes and
// o_stall rises; nothing is dropped or repeated. While the output register
// is empty the block keeps accepting words.

module lattice_site_index_mapper #(
    parameter int MAX_EXTENT = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  lsim_pkg::t_in_word         i_word,
    output logic                       o_valid,
    input  logic                       i_stall,
    output lsim_pkg::t_out_word        o_word,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [lsim_pkg::EXT_W-1:0] i_cfg_data
);
    import lsim_pkg::*;

    localparam int META_N = 3 * DIV_ST;
    localparam logic [EXT_W-1:0] EXT_MAX = EXT_W'(MAX_EXTENT);
    localparam logic [EXT_W-1:0] EXT_RST = EXT_W'(4);

    typedef struct packed {
        t_op               op;
        logic              par_in;
        logic              err;
        logic              wpar;
        logic [COUT_W-1:0] w0;
        logic [COUT_W-1:0] w1;
        logic [COUT_W-1:0] w2;
        logic [COUT_W-1:0] w3;
        logic [IDX_W-1:0]  acc;
    } t_meta;

    logic [EXT_W-1:0] r_ext_x, r_ext_y, r_ext_z, r_ext_t;
    logic [EXT_W-1:0] cfg_val;

    logic en;
    logic r_v [META_N];
    t_meta r_meta [META_N];
    t_meta n_meta [META_N];
    logic [COUT_W-1:0] r_xd [2*DIV_ST];
    logic [COUT_W-1:0] r_yd [DIV_ST];
    logic r_ov;
    t_out_word r_out, n_out;

    logic [DIV_W-1:0]  num0, q1, q2, q3;
    logic [COUT_W-1:0] rem1, rem2, rem3;

    assign en      = !r_ov || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_ov;
    assign o_word  = r_out;

    // extent registers, clamped on write
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_val = EXT_W'(1);
        end else if (i_cfg_data > EXT_MAX) begin
            cfg_val = EXT_MAX;
        end else begin
            cfg_val = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_x <= EXT_RST;
            r_ext_y <= EXT_RST;
            r_ext_z <= EXT_RST;
            r_ext_t <= EXT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXT_X: r_ext_x <= cfg_val;
                CFG_EXT_Y: r_ext_y <= cfg_val;
                CFG_EXT_Z: r_ext_z <= cfg_val;
                CFG_EXT_T: r_ext_t <= cfg_val;
                default: ;
            endcase
        end
    end

    function automatic logic [COUT_W:0] wrap(input logic [CRD_W-1:0] c,
                                             input logic [EXT_W-1:0] n);
        logic signed [CRD_W:0] sc, sn, r;
        logic ok;
        sc = {c[CRD_W-1], c};
        sn = {2'b00, n};
        ok = (sc >= -sn) && (sc < (sn <<< 1));
        if (sc < 0) begin
            r = sc + sn;
        end else if (sc >= sn) begin
            r = sc - sn;
        end else begin
            r = sc;
        end
        return {!ok, r[COUT_W-1:0]};
    endfunction

    // coordinate path: wrap, then three multiply-add stages
    always_comb begin
        logic [COUT_W:0] a, b, c, d;
        a = wrap(i_word.coord_x, r_ext_x);
        b = wrap(i_word.coord_y, r_ext_y);
        c = wrap(i_word.coord_z, r_ext_z);
        d = wrap(i_word.coord_t, r_ext_t);
        n_meta[0].op     = i_word.op;
        n_meta[0].par_in = i_word.parity_in;
        n_meta[0].err    = a[COUT_W] | b[COUT_W] | c[COUT_W] | d[COUT_W];
        n_meta[0].wpar   = a[0] ^ b[0] ^ c[0] ^ d[0];
        n_meta[0].w0     = a[COUT_W-1:0];
        n_meta[0].w1     = b[COUT_W-1:0];
        n_meta[0].w2     = c[COUT_W-1:0];
        n_meta[0].w3     = d[COUT_W-1:0];
        n_meta[0].acc    = '0;
        for (int k = 1; k < META_N; k++) begin
            n_meta[k] = r_meta[k-1];
        end
        n_meta[1].acc = IDX_W'(17'(r_ext_z) * 17'(r_meta[0].w3) + 17'(r_meta[0].w2));
        n_meta[2].acc = IDX_W'(26'(r_ext_y) * r_meta[1].acc[16:0] + 26'(r_meta[1].w1));
        n_meta[3].acc = IDX_W'(35'(r_ext_x) * 35'(r_meta[2].acc[25:0])
                               + 35'(r_meta[2].w0));
    end

    // index path: x, y, z peeled off by three dividers in series
    assign num0 = (i_word.op == OP_FROM_EO) ? {i_word.site_index, 1'b0}
                                            : {1'b0, i_word.site_index};

    lsim_div u_div_x (.i_clk(i_clk), .i_en(en), .i_num(num0), .i_den(r_ext_x),
                      .o_quo(q1), .o_rem(rem1));
    lsim_div u_div_y (.i_clk(i_clk), .i_en(en), .i_num(q1), .i_den(r_ext_y),
                      .o_quo(q2), .o_rem(rem2));
    lsim_div u_div_z (.i_clk(i_clk), .i_en(en), .i_num(q2), .i_den(r_ext_z),
                      .o_quo(q3), .o_rem(rem3));

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < META_N; k++) begin
                r_meta[k] <= n_meta[k];
            end
            r_xd[0] <= rem1;
            for (int k = 1; k < 2 * DIV_ST; k++) begin
                r_xd[k] <= r_xd[k-1];
            end
            r_yd[0] <= rem2;
            for (int k = 1; k < DIV_ST; k++) begin
                r_yd[k] <= r_yd[k-1];
            end
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < META_N; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < META_N; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_ov <= r_v[META_N-1];
        end
    end

    // result assembly
    always_comb begin
        t_meta             m;
        logic [EXT_W-1:0]  c0;
        logic [COUT_W-1:0] tq;
        logic              err;
        m   = r_meta[META_N-1];
        tq  = q3[COUT_W-1:0];
        c0  = {1'b0, r_xd[2*DIV_ST-1]};
        err = 1'b0;
        n_out = '0;
        if (m.op == OP_TO_LEX || m.op == OP_TO_EO) begin
            err = m.err;
            n_out.index_out  = (m.op == OP_TO_EO) ? (m.acc >> 1) : m.acc;
            n_out.parity_out = m.wpar;
        end else begin
            // quotient at or above extent_t means the index is beyond the volume
            if (q3 >= DIV_W'(r_ext_t)) begin
                err = 1'b1;
            end
            if (m.op == OP_FROM_EO) begin
                c0 = c0 + EXT_W'(r_yd[DIV_ST-1][0] ^ rem3[0] ^ tq[0] ^ m.par_in);
            end
            if (c0 >= r_ext_x) begin
                err = 1'b1;
            end
            n_out.x_out      = c0[COUT_W-1:0];
            n_out.y_out      = r_yd[DIV_ST-1];
            n_out.z_out      = rem3;
            n_out.t_out      = tq;
            n_out.parity_out = c0[0] ^ r_yd[DIV_ST-1][0] ^ rem3[0] ^ tq[0];
        end
        if (err) begin
            n_out = '0;
            n_out.range_error = 1'b1;
        end
    end

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.range_error) |-> (o_word.index_out == '0
            && o_word.x_out == '0 && o_word.y_out == '0 && o_word.z_out == '0
            && o_word.t_out == '0 && !o_word.parity_out))
        else $error("error word carries nonzero fields");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.index_out != '0) |-> (o_word.x_out == '0
            && o_word.y_out == '0 && o_word.z_out == '0 && o_word.t_out == '0))
        else $error("index and coordinates both set");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && $past(i_rst_n)) |=> ($stable(r_v[0]) && $stable(r_v[META_N-1])
            && $stable(r_ov)))
        else $error("pipeline moved while frozen");

endmodule

[src/lsim_div.sv]
`timescale 1ns / 1ps
// pipelined restoring divider: 33-bit dividend by a 9-bit extent
// depends on lsim_pkg; DIV_ST register stages, DIV_BPS quotient bits each

module lsim_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [lsim_pkg::DIV_W-1:0]  i_num,
    input  logic [lsim_pkg::EXT_W-1:0]  i_den,
    output logic [lsim_pkg::DIV_W-1:0]  o_quo,
    output logic [lsim_pkg::COUT_W-1:0] o_rem
);
    import lsim_pkg::*;

    // dividend bits are replaced by quotient bits as they are consumed
    logic [DIV_W-1:0]  r_w [DIV_ST];
    logic [COUT_W-1:0] r_r [DIV_ST];
    logic [DIV_W-1:0]  n_w [DIV_ST];
    logic [COUT_W-1:0] n_r [DIV_ST];

    always_comb begin
        logic [DIV_W-1:0]  w;
        logic [COUT_W-1:0] r;
        logic [EXT_W-1:0]  t;
        int                pos;
        for (int k = 0; k < DIV_ST; k++) begin
            if (k == 0) begin
                w = i_num;
                r = '0;
            end else begin
                w = r_w[k-1];
                r = r_r[k-1];
            end
            for (int j = 0; j < DIV_BPS; j++) begin
                pos = DIV_W - 1 - (k * DIV_BPS + j);
                if (pos >= 0) begin
                    t = {r, w[pos]};
                    if (t >= i_den) begin
                        t = t - i_den;
                        w[pos] = 1'b1;
                    end else begin
                        w[pos] = 1'b0;
                    end
                    r = t[COUT_W-1:0];
                end
            end
            n_w[k] = w;
            n_r[k] = r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_ST; k++) begin
                r_w[k] <= n_w[k];
                r_r[k] <= n_r[k];
            end
        end
    end

    assign o_quo = r_w[DIV_ST-1];
    assign o_rem = r_r[DIV_ST-1];

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// testbench for lattice_site_index_mapper: directed and random words checked
// against an in-bench predictor of the coordinate/index mapping
// depends on src/lsim_pkg.sv and src/lattice_site_index_mapper.sv

module tb;
    import lsim_pkg::*;

    localparam int MAXE    = 256;
    localparam int LATENCY = 19;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    logic [EXT_W-1:0] cfg_data;

    int unsigned ext_x, ext_y, ext_z, ext_t;
    t_out_word   expected_q[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;

    lattice_site_index_mapper i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (out_stall),
        .i_word     (in_word),
        .o_valid    (out_valid),
        .i_stall    (in_stall),
        .o_word     (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned clamp_ext(logic [EXT_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAXE) return MAXE;
        return v;
    endfunction

    // wrap by one extent; returns -1 if outside [-n, 2n)
    function automatic int wrap1(logic signed [CRD_W-1:0] c, int n);
        int v;
        v = c;
        if (v < -n || v >= 2 * n) return -1;
        if (v < 0) return v + n;
        if (v >= n) return v - n;
        return v;
    endfunction

    function automatic t_out_word map_site(t_in_word w);
        t_out_word r;
        int wx, wy, wz, wt;
        longint unsigned idx, vol;
        int unsigned cx, cy, cz, ct;
        logic bad;
        r = '0;
        bad = 1'b0;
        vol = longint'(ext_x) * ext_y * ext_z * ext_t;
        if (w.op == OP_TO_LEX || w.op == OP_TO_EO) begin
            wx = wrap1(w.coord_x, ext_x);
            wy = wrap1(w.coord_y, ext_y);
            wz = wrap1(w.coord_z, ext_z);
            wt = wrap1(w.coord_t, ext_t);
            if (wx < 0 || wy < 0 || wz < 0 || wt < 0) begin
                bad = 1'b1;
            end else begin
                idx = wx + ext_x * (wy + ext_y * (wz + longint'(ext_z) * wt));
                if (w.op == OP_TO_EO) idx = idx >> 1;
                r.index_out  = idx[31:0];
                r.parity_out = 1'((wx + wy + wz + wt) & 1);
            end
        end else begin
            idx = w.site_index;
            if (w.op == OP_FROM_EO) idx = idx << 1;
            if (idx >= vol) begin
                bad = 1'b1;
            end else begin
                cx = idx % ext_x; idx = idx / ext_x;
                cy = idx % ext_y; idx = idx / ext_y;
                cz = idx % ext_z; idx = idx / ext_z;
                ct = idx % ext_t;
                if (w.op == OP_FROM_EO) begin
                    cx += (cy + cz + ct + w.parity_in) & 1;
                    if (cx >= ext_x) bad = 1'b1;
                end
                r.x_out = COUT_W'(cx); r.y_out = COUT_W'(cy);
                r.z_out = COUT_W'(cz); r.t_out = COUT_W'(ct);
                r.parity_out = 1'((cx + cy + cz + ct) & 1);
            end
        end
        if (bad) begin
            r = '0;
            r.range_error = 1'b1;
        end
        return r;
    endfunction

    // valid stays high after the word is taken; the next send or drain moves it
    task automatic send_word(t_in_word w);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (out_stall) @(posedge clk);
        expected_q.push_back(map_site(w));
        @(negedge clk);
    endtask

    // receiver stall and result check
    always @(negedge clk) begin
        if (!rst_n) begin
            in_stall <= 1'b0;
        end else begin
            in_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_out_word e;
        if (rst_n && out_valid && !in_stall) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", out_word);
            end else begin
                e = expected_q.pop_front();
                if (out_word !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp idx %h x %h y %h z %h t %h p %b e %b,",
                                  " got idx %h x %h y %h z %h t %h p %b e %b"},
                                 e.index_out, e.x_out, e.y_out, e.z_out, e.t_out,
                                 e.parity_out, e.range_error, out_word.index_out,
                                 out_word.x_out, out_word.y_out, out_word.z_out,
                                 out_word.t_out, out_word.parity_out,
                                 out_word.range_error);
                end
            end
        end
    end

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_extent(logic [1:0] idx, logic [EXT_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        @(negedge clk);
        case (idx)
            CFG_EXT_X: ext_x = clamp_ext(v);
            CFG_EXT_Y: ext_y = clamp_ext(v);
            CFG_EXT_Z: ext_z = clamp_ext(v);
            default:   ext_t = clamp_ext(v);
        endcase
    endtask

    task automatic set_extents(logic [EXT_W-1:0] x, logic [EXT_W-1:0] y,
                               logic [EXT_W-1:0] z, logic [EXT_W-1:0] t);
        drain();
        write_extent(CFG_EXT_X, x);
        write_extent(CFG_EXT_Y, y);
        write_extent(CFG_EXT_Z, z);
        write_extent(CFG_EXT_T, t);
        cfg_we <= 1'b0;
    endtask

    function automatic t_in_word make_word(t_op op, int x, int y, int z, int t,
                                           logic [31:0] si, logic p);
        t_in_word w;
        w.op = op;
        w.coord_x = CRD_W'(x); w.coord_y = CRD_W'(y);
        w.coord_z = CRD_W'(z); w.coord_t = CRD_W'(t);
        w.site_index = si;
        w.parity_in = p;
        return w;
    endfunction

    // mostly in-range values with some near or past the wrap limits
    function automatic int pick_coord(int n);
        case ($urandom_range(9))
            0: return $urandom_range(1023) - 512;
            1: return -n;
            2: return 2 * n - 1;
            3: return $urandom_range(2 * n - 1) - n;
            default: return $urandom_range(n - 1);
        endcase
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        longint unsigned vol;
        vol = longint'(ext_x) * ext_y * ext_z * ext_t;
        w = '0;
        w.op = t_op'($urandom_range(3));
        w.coord_x = CRD_W'(pick_coord(ext_x));
        w.coord_y = CRD_W'(pick_coord(ext_y));
        w.coord_z = CRD_W'(pick_coord(ext_z));
        w.coord_t = CRD_W'(pick_coord(ext_t));
        case ($urandom_range(7))
            0: w.site_index = $urandom;
            1: w.site_index = 32'hFFFF_FFFF;
            2: w.site_index = (w.op == OP_FROM_EO) ? 32'((vol + 1) / 2) : 32'(vol);
            default: w.site_index = (vol > 64'hFFFF_FFFF) ? $urandom
                                    : $urandom_range(32'(vol - 1));
        endcase
        w.parity_in = 1'($urandom_range(1));
        return w;
    endfunction

    task automatic test_directed();
        send_word(make_word(OP_TO_LEX, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_TO_LEX, 3, 3, 3, 3, 0, 0));
        send_word(make_word(OP_TO_LEX, -4, 7, -1, 4, 0, 0));
        send_word(make_word(OP_TO_LEX, -5, 0, 0, 0, 0, 0));
        send_word(make_word(OP_TO_EO, 0, 0, 0, 8, 0, 0));
        send_word(make_word(OP_TO_EO, 511, -256, 0, 0, 0, 1));
        send_word(make_word(OP_TO_EO, 1, 2, 3, 3, 32'hFFFF_FFFF, 1));
        send_word(make_word(OP_FROM_LEX, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_FROM_LEX, 0, 0, 0, 0, 255, 0));
        send_word(make_word(OP_FROM_LEX, 0, 0, 0, 0, 256, 0));
        send_word(make_word(OP_FROM_LEX, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
        send_word(make_word(OP_FROM_EO, 0, 0, 0, 0, 0, 0));
        send_word(make_word(OP_FROM_EO, 0, 0, 0, 0, 127, 1));
        send_word(make_word(OP_FROM_EO, 0, 0, 0, 0, 128, 0));
        // odd x extent: parity step may run off the end of the row
        set_extents(3, 0, 511, 1);
        send_word(make_word(OP_FROM_EO, 0, 0, 0, 0, 1, 0));
        send_word(make_word(OP_FROM_EO, 0, 0, 0, 0, 1, 1));
        send_word(make_word(OP_TO_LEX, 5, 0, 255, -1, 0, 0));
        send_word(make_word(OP_TO_EO, -3, -1, 511, 1, 0, 0));
        set_extents(256, 256, 256, 256);
        send_word(make_word(OP_TO_LEX, 255, 511, -256, 255, 0, 0));
        send_word(make_word(OP_FROM_LEX, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
        send_word(make_word(OP_FROM_EO, 0, 0, 0, 0, 32'h7FFF_FFFF, 1));
        send_word(make_word(OP_FROM_EO, 0, 0, 0, 0, 32'h8000_0000, 0));
    endtask

    task automatic test_random(int n);
        repeat (n) send_word(random_word());
    endtask

    task automatic test_config_sweep();
        set_extents(1, 1, 1, 1);
        test_random(30);
        set_extents(5, 2, 7, 3);
        test_random(80);
        set_extents(EXT_W'($urandom_range(511)), EXT_W'($urandom_range(511)),
                    EXT_W'($urandom_range(511)), EXT_W'($urandom_range(511)));
        test_random(60);
        set_extents(256, 1, 256, 2);
        test_random(40);
        set_extents(4, 4, 4, 4);
        test_random(40);
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        mismatches = 0;
        send_idle_pct = 33;
        recv_idle_pct = 58;
        ext_x = 4; ext_y = 4; ext_z = 4; ext_t = 4;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_config_sweep();
        send_idle_pct = 58;
        recv_idle_pct = 33;
        set_extents(6, 5, 3, 9);
        test_random(100);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_extents(2, 3, 4, 5);
        test_random(100);
        drain();
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
src/lsim_pkg.sv
src/lsim_div.sv
src/lattice_site_index_mapper.sv
verif/tb.sv
